// ----- hdl/rafs_pkg.sv -----
// Package for the rotation angle frame selector.
// Holds register indexes, reset values, field widths and the command struct.
// Used by rafs_ctrl, rafs_datapath and rotation_angle_frame_selector.
package rafs_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE   = 2'd2;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [15:0] DEBOUNCE_RESET = 16'd10;
    localparam logic [7:0]  FRAMES_RESET   = 8'd180;
    localparam logic [15:0] TOGGLE_RESET   = 16'd250;

    // Stream widths (fields packed from bit 0, padded to whole bytes).
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 48;

    // The quotient never exceeds eight bits, so the divider runs eight steps.
    localparam int DIV_STEPS = 8;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic update;   // take the request and advance the counters
        logic mul;      // form rot_at_pulse * ms_since_pulse
        logic scale;    // scale by frames_per_rev and load the divider
        logic step;     // one restoring division step
        logic load;     // capture the result into the output register
    } rafs_cmd_t;

endpackage

// ----- hdl/rafs_ctrl.sv -----
// Controller state machine for the rotation angle frame selector.
// Sequences update, multiply, scale, divide and output load.
// Depends on rafs_pkg.
module rafs_ctrl
    import rafs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      m_tready,
    output logic      m_tvalid,
    output rafs_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             m_tvalid_reg;
    logic             out_free;

    // The output register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Command decode from the current state.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:  cmd.update = s_tvalid;
            S_MUL:   cmd.mul    = 1'b1;
            S_SCALE: cmd.scale  = 1'b1;
            S_DIV:   cmd.step   = 1'b1;
            S_OUT:   cmd.load   = out_free;
            default: cmd = '0;
        endcase
    end

    // State, step counter and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A load refills the output register; otherwise a drain empties it.
            if (cmd.load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // The step counter only runs during division.
    a_cnt_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 |-> state_reg == S_DIV)
        else $error("step counter active outside division");

    // A result load always presents a valid result next cycle.
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_tvalid_reg)
        else $error("loaded result not marked valid");

endmodule

// ----- hdl/rafs_datapath.sv -----
// Datapath for the rotation angle frame selector: configuration registers,
// tick counters, multiplier, restoring divider and output register.
// Depends on rafs_pkg; driven by commands from rafs_ctrl.
module rafs_datapath
    import rafs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  reed_edge,
    input  rafs_cmd_t             cmd,
    output logic [M_DATA_W-1:0]   m_tdata
);

    localparam logic [31:0] ALL32 = '1;

    logic [15:0] debounce_reg;
    logic [7:0]  frames_reg;
    logic [15:0] toggle_period_reg;

    logic [31:0] ms_start_reg;
    logic [31:0] ms_pulse_reg;
    logic [31:0] rotations_reg;
    logic [31:0] rot_at_pulse_reg;
    logic [31:0] elapsed_reg;
    logic [15:0] toggle_count_reg;
    logic        model_flag_reg;
    logic        accepted_reg;

    logic [63:0] prod_reg;
    logic [31:0] rem_reg;
    logic [7:0]  low_reg;
    logic        zero_reg;
    logic        clamp_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [31:0] ms_start_inc;
    logic [31:0] ms_pulse_inc;
    logic [31:0] rot_inc;
    logic        edge_ok;
    logic [16:0] tc_plus;
    logic        tc_wrap;
    logic [39:0] scaled;
    logic [32:0] div_num;
    logic [32:0] div_diff;
    logic        div_ge;
    logic [7:0]  frame_sel;

    // Saturating increments and the debounce test.
    assign ms_start_inc = (ms_start_reg == ALL32) ? ms_start_reg : ms_start_reg + 32'd1;
    assign ms_pulse_inc = (ms_pulse_reg == ALL32) ? ms_pulse_reg : ms_pulse_reg + 32'd1;
    assign rot_inc      = (rotations_reg == ALL32) ? rotations_reg : rotations_reg + 32'd1;
    assign edge_ok      = reed_edge && (ms_pulse_inc >= {16'd0, debounce_reg});
    assign tc_plus      = {1'b0, toggle_count_reg} + 17'd1;
    assign tc_wrap      = tc_plus >= {1'b0, toggle_period_reg};

    // Scale the product by the frame count; only used when the product is below 2^32.
    assign scaled = {8'd0, prod_reg[31:0]} * {32'd0, frames_reg};

    // One restoring division step: shift in the next dividend bit and try a subtract.
    assign div_num  = {rem_reg, low_reg[7]};
    assign div_diff = div_num - {1'b0, elapsed_reg};
    assign div_ge   = div_num >= {1'b0, elapsed_reg};

    // Final frame selection with the special cases.
    always_comb begin
        if (zero_reg) begin
            frame_sel = 8'd0;
        end else if (clamp_reg) begin
            frame_sel = frames_reg - 8'd1;
        end else begin
            frame_sel = low_reg;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg      <= DEBOUNCE_RESET;
            frames_reg        <= FRAMES_RESET;
            toggle_period_reg <= TOGGLE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg      <= cfg_wdata;
                CFG_FRAMES:   frames_reg        <= cfg_wdata[7:0];
                CFG_TOGGLE:   toggle_period_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Tick counters, pulse capture and model toggle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_start_reg     <= '0;
            ms_pulse_reg     <= ALL32;
            rotations_reg    <= '0;
            rot_at_pulse_reg <= '0;
            elapsed_reg      <= '0;
            toggle_count_reg <= '0;
            model_flag_reg   <= 1'b1;
            accepted_reg     <= 1'b0;
        end else if (cmd.update) begin
            ms_start_reg <= ms_start_inc;
            accepted_reg <= edge_ok;
            if (edge_ok) begin
                ms_pulse_reg     <= '0;
                rotations_reg    <= rot_inc;
                rot_at_pulse_reg <= rot_inc;
                elapsed_reg      <= ms_start_inc;
                if (tc_wrap) begin
                    toggle_count_reg <= '0;
                    model_flag_reg   <= ~model_flag_reg;
                end else begin
                    toggle_count_reg <= tc_plus[15:0];
                end
            end else begin
                ms_pulse_reg <= ms_pulse_inc;
            end
        end
    end

    // Multiplier, divider and output register.
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= {32'd0, rot_at_pulse_reg} * {32'd0, ms_pulse_reg};
        end
        if (cmd.scale) begin
            zero_reg  <= (frames_reg == 8'd0) || (elapsed_reg == 32'd0);
            clamp_reg <= (prod_reg[63:32] != 32'd0) || (prod_reg[31:0] >= elapsed_reg);
            rem_reg   <= scaled[39:8];
            low_reg   <= scaled[7:0];
        end
        if (cmd.step) begin
            rem_reg <= div_ge ? div_diff[31:0] : div_num[31:0];
            low_reg <= {low_reg[6:0], div_ge};
        end
        if (cmd.load) begin
            m_tdata_reg <= {6'd0, rotations_reg, accepted_reg, model_flag_reg, frame_sel};
        end
    end

    assign m_tdata = m_tdata_reg;

    // The partial remainder stays below the divisor on the normal path.
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && !zero_reg && !clamp_reg |-> rem_reg < elapsed_reg)
        else $error("division remainder out of range");

    // An accepted pulse restarts the interval and records the elapsed time.
    a_pulse_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update && edge_ok |=> ms_pulse_reg == 32'd0 && elapsed_reg == ms_start_reg)
        else $error("pulse capture inconsistent");

    // The rotation count never decreases.
    a_rot_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> rotations_reg >= $past(rotations_reg))
        else $error("rotation count decreased");

endmodule

// ----- hdl/rotation_angle_frame_selector.sv -----
// Top level of the rotation angle frame selector.
// Joins rafs_ctrl and rafs_datapath; depends on rafs_pkg.
//
//  Channel  Dir  Fields (low bit first)
//  s_       in   tdata: reed_edge[0]
//  m_       out  tdata: frame_index[7:0], model_select[8], pulse_accepted[9],
//                       rotation_total[41:10]
//  cfg_     in   cfg_index 0 debounce_ms, 1 frames_per_rev, 2 toggle_period
//
// Each request runs through these states in order: update the counters, the
// 32x32 multiply, scale and load the divider, eight restoring division
// steps, and load the output register.
// A new request is taken once the previous result sits in the output register.
// A stalled output holds the last step until the result register drains.
// Synchronous active-low reset restores state, counters and config registers.
module rotation_angle_frame_selector
    import rafs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // reed_edge[0], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // frame_index, model_select,
                                             // pulse_accepted, rotation_total
);

    rafs_cmd_t cmd;

    // Sequencer.
    rafs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // Counters and arithmetic.
    rafs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .reed_edge (s_tdata[0]),
        .cmd       (cmd),
        .m_tdata   (m_tdata)
    );

endmodule
